// ===== rtl/spl_pkg.sv =====
// shared types and codes for the slot pool with linked queue
`default_nettype none

package spl_pkg;

	// field widths of the request, result and configuration channels
	localparam int SLOT_W  = 8;
	localparam int CNT_W   = 6;
	localparam int RES_W   = 5;
	localparam int REQ_W   = 3;
	localparam int STAT_W  = 2;
	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 16;
	localparam int CFG_DW  = 32;
	localparam int CFG_AW  = 3;

	// largest slot count the configuration register may reset to
	localparam int MAX_RESET_COUNT = 32;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC    = 3'd0,
		REQ_FREE     = 3'd1,
		REQ_ENQ      = 3'd2,
		REQ_DEQ      = 3'd3,
		REQ_DEQ_HEAD = 3'd4
	} req_kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK         = 2'd0,
		STAT_BAD        = 2'd1,
		STAT_WAS_FREE   = 2'd2,
		STAT_NOT_QUEUED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SLOT_FREE   = 2'd0,
		SLOT_ALLOC  = 2'd1,
		SLOT_QUEUED = 2'd2
	} slot_state_t;

	// one request as it enters the pool
	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [SLOT_W-1:0] slot;
	} req_t;

	// one result as it leaves the pool
	typedef struct packed {
		status_t          status;
		logic [RES_W-1:0] result_slot;
		logic [CNT_W-1:0] allocated_count;
		logic             queue_empty;
	} rsp_t;

	// configuration write towards the pool
	typedef struct packed {
		logic             we;
		logic [CNT_W-1:0] value;
	} cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/spl_pool.sv =====
// slot pool state with free list, linked queue and single-pass request update
`default_nettype none

module spl_pool
	import spl_pkg::*;
#(
	parameter int SLOTS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_wr_t          cfg,
	input  wire logic             fire,
	input  wire req_t             req,
	output rsp_t                  rsp,
	output logic [CNT_W-1:0]      slot_count_q
);

	localparam int LW = $clog2(SLOTS + 1);
	localparam int IW = $clog2(SLOTS);
	localparam logic [LW-1:0] NONE = LW'(SLOTS);
	localparam int RESET_COUNT = (SLOTS < MAX_RESET_COUNT) ? SLOTS : MAX_RESET_COUNT;

	// pool storage
	slot_state_t   state_q [SLOTS];
	logic [LW-1:0] nxt_q   [SLOTS];
	logic [LW-1:0] prv_q   [SLOTS];
	logic [LW-1:0] fhead_q;
	logic [LW-1:0] qhead_q;
	logic [LW-1:0] qtail_q;
	logic [LW-1:0] used_q;

	function automatic logic in_pool(input logic [SLOT_W-1:0] v, input logic [CNT_W-1:0] cnt);
		return (v < SLOT_W'(cnt)) && (v < SLOT_W'(SLOTS));
	endfunction

	// target slot: named slot, free list top or queue head
	logic [SLOT_W-1:0] t;
	logic              t_ok;
	logic [IW-1:0]     t_idx;
	slot_state_t       t_st;
	logic [LW-1:0]     t_nxt;
	logic [LW-1:0]     t_prv;
	logic [LW-1:0]     t_link;

	always_comb begin
		case (req.req_type)
			REQ_ALLOC:    t = SLOT_W'(fhead_q);
			REQ_DEQ_HEAD: t = SLOT_W'(qhead_q);
			default:      t = req.slot;
		endcase
	end

	assign t_ok   = in_pool(t, slot_count_q);
	assign t_idx  = t[IW-1:0];
	assign t_st   = state_q[t_idx];
	assign t_nxt  = nxt_q[t_idx];
	assign t_prv  = prv_q[t_idx];
	assign t_link = t[LW-1:0];

	// decision and write set for this request
	status_t       status;
	logic          nxt_a_en;
	logic [IW-1:0] nxt_a_idx;
	logic [LW-1:0] nxt_a_data;
	logic          nxt_t_en;
	logic [LW-1:0] nxt_t_data;
	logic          prv_a_en;
	logic [IW-1:0] prv_a_idx;
	logic [LW-1:0] prv_a_data;
	logic          prv_t_en;
	logic [LW-1:0] prv_t_data;
	logic          st_t_en;
	slot_state_t   st_t_data;
	logic [LW-1:0] fhead_d;
	logic [LW-1:0] qhead_d;
	logic [LW-1:0] qtail_d;
	logic [LW-1:0] used_d;
	logic          qhead_ok;
	logic          qtail_ok;
	logic          nxt_ok;
	logic          prv_ok;

	assign qhead_ok = in_pool(SLOT_W'(qhead_q), slot_count_q);
	assign qtail_ok = in_pool(SLOT_W'(qtail_q), slot_count_q);
	assign nxt_ok   = in_pool(SLOT_W'(t_nxt), slot_count_q);
	assign prv_ok   = in_pool(SLOT_W'(t_prv), slot_count_q);

	always_comb begin
		status     = STAT_BAD;
		nxt_a_en   = 1'b0;
		nxt_a_idx  = '0;
		nxt_a_data = NONE;
		nxt_t_en   = 1'b0;
		nxt_t_data = NONE;
		prv_a_en   = 1'b0;
		prv_a_idx  = '0;
		prv_a_data = NONE;
		prv_t_en   = 1'b0;
		prv_t_data = NONE;
		st_t_en    = 1'b0;
		st_t_data  = SLOT_FREE;
		fhead_d    = fhead_q;
		qhead_d    = qhead_q;
		qtail_d    = qtail_q;
		used_d     = used_q;
		case (req.req_type)
			REQ_ALLOC: begin
				if (t_ok) begin
					status    = STAT_OK;
					fhead_d   = t_nxt;
					nxt_t_en  = 1'b1;
					st_t_en   = 1'b1;
					st_t_data = SLOT_ALLOC;
					used_d    = used_q + LW'(1);
				end
			end
			REQ_FREE: begin
				if (!t_ok) begin
					status = STAT_BAD;
				end else if (t_st == SLOT_FREE) begin
					status = STAT_WAS_FREE;
				end else if (t_st == SLOT_ALLOC) begin
					status     = STAT_OK;
					nxt_t_en   = 1'b1;
					nxt_t_data = fhead_q;
					st_t_en    = 1'b1;
					st_t_data  = SLOT_FREE;
					fhead_d    = t_link;
					used_d     = used_q - LW'(1);
				end
			end
			REQ_ENQ: begin
				if (!t_ok) begin
					status = STAT_BAD;
				end else if (t_st == SLOT_FREE) begin
					status = STAT_WAS_FREE;
				end else if (t_st == SLOT_ALLOC) begin
					status   = STAT_OK;
					prv_t_en = 1'b1;
					if (!qhead_ok) begin
						qhead_d    = t_link;
						prv_t_data = NONE;
					end else begin
						// append behind the current tail
						nxt_a_en   = qtail_ok;
						nxt_a_idx  = qtail_q[IW-1:0];
						nxt_a_data = t_link;
						prv_t_data = qtail_q;
					end
					nxt_t_en  = 1'b1;
					qtail_d   = t_link;
					st_t_en   = 1'b1;
					st_t_data = SLOT_QUEUED;
				end
			end
			REQ_DEQ, REQ_DEQ_HEAD: begin
				if (!t_ok) begin
					status = STAT_BAD;
				end else if (t_st == SLOT_FREE) begin
					status = STAT_WAS_FREE;
				end else if (t_st == SLOT_ALLOC) begin
					status = STAT_NOT_QUEUED;
				end else if (!qhead_ok) begin
					status = STAT_BAD;
				end else begin
					status = STAT_OK;
					// unlink from the predecessor side
					if (qhead_q == t_link) begin
						qhead_d = t_nxt;
					end else if (prv_ok) begin
						nxt_a_en   = 1'b1;
						nxt_a_idx  = t_prv[IW-1:0];
						nxt_a_data = t_nxt;
					end
					// unlink from the successor side
					if (qtail_q == t_link) begin
						qtail_d = t_prv;
					end else if (nxt_ok) begin
						prv_a_en   = 1'b1;
						prv_a_idx  = t_nxt[IW-1:0];
						prv_a_data = t_prv;
					end
					nxt_t_en  = 1'b1;
					prv_t_en  = 1'b1;
					st_t_en   = 1'b1;
					st_t_data = SLOT_ALLOC;
				end
			end
			default: begin
				status = STAT_BAD;
			end
		endcase
	end

	// result fields after the request
	logic              ok;
	logic [SLOT_W-1:0] used_ext;

	assign ok       = (status == STAT_OK);
	assign used_ext = SLOT_W'(used_d);

	assign rsp.status          = status;
	assign rsp.result_slot     = ok ? t[RES_W-1:0] : '0;
	assign rsp.allocated_count = used_ext[CNT_W-1:0];
	assign rsp.queue_empty     = !in_pool(SLOT_W'(qhead_d), slot_count_q);

	// accepted slot count write
	logic cfg_ok;

	assign cfg_ok = cfg.we && (cfg.value != '0) && (SLOT_W'(cfg.value) <= SLOT_W'(SLOTS));

	// slot count, slot state, forward links, list heads and used count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= CNT_W'(RESET_COUNT);
			fhead_q      <= '0;
			qhead_q      <= NONE;
			qtail_q      <= NONE;
			used_q       <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				state_q[i] <= SLOT_FREE;
				nxt_q[i]   <= (i + 1 < RESET_COUNT) ? LW'(i + 1) : NONE;
			end
		end else if (cfg_ok) begin
			slot_count_q <= cfg.value;
			fhead_q      <= '0;
			qhead_q      <= NONE;
			qtail_q      <= NONE;
			used_q       <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				state_q[i] <= SLOT_FREE;
				nxt_q[i]   <= (SLOT_W'(i + 1) < SLOT_W'(cfg.value)) ? LW'(i + 1) : NONE;
			end
		end else if (fire && ok) begin
			fhead_q <= fhead_d;
			qhead_q <= qhead_d;
			qtail_q <= qtail_d;
			used_q  <= used_d;
			for (int i = 0; i < SLOTS; i++) begin
				if (st_t_en && t_idx == IW'(i)) begin
					state_q[i] <= st_t_data;
				end
				if (nxt_t_en && t_idx == IW'(i)) begin
					nxt_q[i] <= nxt_t_data;
				end else if (nxt_a_en && nxt_a_idx == IW'(i)) begin
					nxt_q[i] <= nxt_a_data;
				end
			end
		end
	end

	// backward links, only meaningful once a slot has been queued
	always_ff @(posedge clk) begin
		if (fire && ok && !cfg_ok) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (prv_t_en && t_idx == IW'(i)) begin
					prv_q[i] <= prv_t_data;
				end else if (prv_a_en && prv_a_idx == IW'(i)) begin
					prv_q[i] <= prv_a_data;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/slot_pool_with_linked_queue_core.sv =====
// top level: request and result stages, configuration port and the slot pool
//
//  channel  | direction | fields (lowest bit first)
//  s_*      | in        | tdata: slot[7:0]; tuser: req_type[2:0]
//  m_*      | out       | tdata: result_slot, allocated_count, queue_empty; tuser: status
//  apb      | in/out    | register 0 at address 0: slot_count[5:0]
//
// one request per cycle while results are not stalled; a request is held in the input
// register and its result is then registered in the output register.
// the pool state is updated as a request moves from the input to the output
// register, so the next request sees it at once.
// reset leaves a 32-slot pool (fewer if SLOTS is smaller) all free, queue empty.
// a stalled result holds the input register, which then holds s_tready low.
`default_nettype none

module slot_pool_with_linked_queue_core
	import spl_pkg::*;
#(
	parameter int SLOTS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// request stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [TDATA_IN_W-1:0]  s_tdata,   // slot[7:0]
	input  wire logic [REQ_W-1:0]       s_tuser,   // req_type[2:0]
	// result stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [TDATA_OUT_W-1:0]      m_tdata,   // result_slot[4:0], allocated_count[10:5],
	                                               // queue_empty[11], zeros[15:12]
	output logic [STAT_W-1:0]           m_tuser,   // status[1:0]
	// configuration port
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [CFG_AW-1:0]      paddr,
	input  wire logic [CFG_DW-1:0]      pwdata,
	output logic [CFG_DW-1:0]           prdata,
	output logic                        pready
);

	// input register
	logic valid_s1;
	req_t req_s1;
	// output register
	logic valid_s2;
	rsp_t rsp_s2;

	logic    adv_s1;
	rsp_t    rsp;
	cfg_wr_t cfg;
	logic [CNT_W-1:0] slot_count;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.req_type <= s_tuser;
			req_s1.slot     <= s_tdata[SLOT_W-1:0];
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_s2 <= rsp;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = rsp_s2.status;
	assign m_tdata  = {(TDATA_OUT_W - RES_W - CNT_W - 1)'(0), rsp_s2.queue_empty,
		rsp_s2.allocated_count, rsp_s2.result_slot};

	// configuration register access
	assign pready    = 1'b1;
	assign cfg.we    = psel && penable && pwrite && !paddr[2];
	assign cfg.value = pwdata[CNT_W-1:0];
	assign prdata    = paddr[2] ? '0 : CFG_DW'(slot_count);

	spl_pool #(
		.SLOTS(SLOTS)
	) u_pool (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.fire        (adv_s1),
		.req         (req_s1),
		.rsp         (rsp),
		.slot_count_q(slot_count)
	);

endmodule

`default_nettype wire
